// ----- rtl/core/ptb_pkg.sv -----
// Package for the periodic timer bank: operation codes, field widths and the
// packed transaction types shared by the top level and the slot module.
// No dependencies.
package ptb_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MASK_W = 8;

  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP    = 2'd1;
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
  } ptb_in_t;

  typedef struct packed {
    logic              start_ok;
    logic [MASK_W-1:0] fired_mask;
  } ptb_out_t;

  // Command broadcast from the top level to every slot, already qualified by
  // the cycle in which the held transaction is executed.
  typedef struct packed {
    logic              start;
    logic              stop;
    logic              process;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
  } ptb_cmd_t;

endpackage

// ----- rtl/core/ptb_slot.sv -----
// One timer slot: enable bit, period and reference time, with the expiry
// check and reference update. Depends on ptb_pkg.
module ptb_slot (
  input  logic              clk,
  input  logic              rst_n,
  input  ptb_pkg::ptb_cmd_t cmd,
  input  logic              sel,
  output logic              enabled,
  output logic              fired
);
  import ptb_pkg::*;

  logic              en_r;
  logic              en_nxt;
  logic [TIME_W-1:0] period_r;
  logic [TIME_W-1:0] ref_r;
  logic [TIME_W-1:0] ref_nxt;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] behind;
  logic              due;
  logic              arm;

  // Time since the reference; after one period step the slot is still
  // behind by elapsed - period, all modulo 2^32.
  assign elapsed = cmd.now - ref_r;
  assign behind  = elapsed - period_r;
  assign due     = en_r && (elapsed >= period_r);
  assign ref_nxt = (behind > period_r) ? cmd.now : ref_r + period_r;
  assign arm     = cmd.start && sel && !en_r;

  assign enabled = en_r;
  assign fired   = cmd.process && due;

  always_comb begin
    en_nxt = en_r;
    if (arm) begin
      en_nxt = 1'b1;
    end else if (cmd.stop && sel) begin
      en_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      en_r <= en_nxt;
    end
  end

  // Period and reference are only read while the slot is enabled, and a
  // start writes both, so they carry no reset.
  always_ff @(posedge clk) begin
    if (arm) begin
      period_r <= cmd.period;
      ref_r    <= cmd.now;
    end else if (fired) begin
      ref_r    <= ref_nxt;
    end
  end

endmodule

// ----- rtl/core/periodic_timer_bank.sv -----
// Top level of the periodic timer bank: input register, a row of timer
// slots and the result register. Depends on ptb_pkg and ptb_slot.
//
// The bank holds NUM_SLOTS periodic timers. A start transaction arms an idle
// slot with a period and takes the current time as its reference, reporting
// start_ok; a start on a running slot, or on a slot index the bank does not
// have, is refused. A stop transaction disarms a slot. A process transaction
// carries the current time and checks every enabled slot at once: a slot
// fires when now minus its reference (modulo 2^32) is at least its period,
// its reference then moves on by one period, or jumps to now if it is still
// more than a period behind. The result reports the fired slots as a mask;
// only slots 0 to 7 can be addressed and reported. Every transaction gives
// exactly one result. The block takes one transaction per clock cycle as long
// as the result side does not stall. The accepting edge loads the input
// register, and the edge at which the held transaction executes updates the
// slots and writes the result register together, setting out_valid; the next
// transaction always sees the updated slot state. The path that sets the
// clock is the per-slot subtract, compare and reference update between the
// input register and the slot registers.
module periodic_timer_bank #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptb_pkg::ptb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptb_pkg::ptb_out_t out_data
);
  import ptb_pkg::*;

  // Slots that can be addressed by the slot field and shown in the mask.
  localparam int unsigned ADDR_SLOTS = 1 << SLOT_W;
  localparam int unsigned MASK_SLOTS = (NUM_SLOTS < MASK_W) ? NUM_SLOTS : MASK_W;

  // Input register: holds the transaction that is executed next.
  logic     in_valid_r;
  logic     in_valid_nxt;
  ptb_in_t  in_data_r;

  // Result register.
  logic     out_valid_r;
  logic     out_valid_nxt;
  ptb_out_t out_data_r;
  ptb_out_t out_data_nxt;

  logic     advance;
  ptb_cmd_t cmd;

  logic [NUM_SLOTS-1:0] slot_sel;
  logic [NUM_SLOTS-1:0] slot_en;
  logic [NUM_SLOTS-1:0] slot_fired;
  logic [MASK_W-1:0]    mask;

  // The held transaction executes when the result register is free or is
  // being emptied in the same cycle.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cmd.start   = advance && (in_data_r.operation == OP_START);
    cmd.stop    = advance && (in_data_r.operation == OP_STOP);
    cmd.process = advance && (in_data_r.operation == OP_PROCESS);
    cmd.period  = in_data_r.period;
    cmd.now     = in_data_r.now;
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    // Slots beyond the range of the slot field are never selected.
    if (i < ADDR_SLOTS) begin : g_addr
      assign slot_sel[i] = (in_data_r.slot == SLOT_W'(i));
    end else begin : g_noaddr
      assign slot_sel[i] = 1'b0;
    end

    ptb_slot u_slot (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .sel     (slot_sel[i]),
      .enabled (slot_en[i]),
      .fired   (slot_fired[i])
    );
  end

  // Only the first eight slots appear in the mask.
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < MASK_SLOTS) begin : g_used
      assign mask[b] = slot_fired[b];
    end else begin : g_unused
      assign mask[b] = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt.start_ok   = cmd.start && |(slot_sel & ~slot_en);
    out_data_nxt.fired_mask = mask;
  end

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A result never reports both an accepted start and fired slots.
  a_ok_excl_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.start_ok && (out_data_r.fired_mask != '0)))
    else $error("start_ok and fired_mask both set in one result");

  // An executed transaction always leaves a result in the output register.
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("executed transaction produced no result");

  // With the result register empty, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while result register empty");

  // A slot that fires must have been enabled at the time of the check.
  a_fire_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_fired & ~slot_en) == '0)
    else $error("disabled slot fired");

endmodule

// ----- bench/ptb_scoreboard_pkg.sv -----
// Scoreboard for the periodic timer bank test: a shadow copy of the slot
// state that predicts each result, and the queue of results still owed.
// Depends on ptb_pkg.
package ptb_scoreboard_pkg;

  import ptb_pkg::*;

  // The one operation code that the bank leaves unused.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned BANK_SLOTS = 8;

  class timer_bank_scoreboard;

    bit                armed    [BANK_SLOTS];
    logic [TIME_W-1:0] interval [BANK_SLOTS];
    logic [TIME_W-1:0] anchor   [BANK_SLOTS];
    ptb_out_t          owed_results[$];
    int                error_count;

    function new();
      foreach (armed[i]) begin
        armed[i]    = 1'b0;
        interval[i] = '0;
        anchor[i]   = '0;
      end
      error_count = 0;
    endfunction

    // Applies one accepted command to the shadow slots and queues its result.
    function void note_command(ptb_in_t cmd);
      ptb_out_t          res;
      logic [TIME_W-1:0] elapsed;
      res = '0;
      case (cmd.operation)
        OP_START: begin
          if (!armed[cmd.slot]) begin
            interval[cmd.slot] = cmd.period;
            anchor[cmd.slot]   = cmd.now;
            armed[cmd.slot]    = 1'b1;
            res.start_ok       = 1'b1;
          end
        end
        OP_STOP: begin
          armed[cmd.slot] = 1'b0;
        end
        OP_PROCESS: begin
          for (int i = 0; i < BANK_SLOTS; i++) begin
            elapsed = cmd.now - anchor[i];
            if (armed[i] && elapsed >= interval[i]) begin
              anchor[i] = anchor[i] + interval[i];
              elapsed   = cmd.now - anchor[i];
              // Still more than a period behind: resynchronize to now.
              if (elapsed > interval[i]) begin
                anchor[i] = cmd.now;
              end
              res.fired_mask[i] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      owed_results.push_back(res);
    endfunction

    function void check_result(ptb_out_t got);
      ptb_out_t want;
      if (owed_results.size() == 0) begin
        $error("result arrived with no expectation pending: start_ok %0d, fired_mask 0x%02h",
               got.start_ok, got.fired_mask);
        error_count++;
        return;
      end
      want = owed_results.pop_front();
      if (got.start_ok !== want.start_ok) begin
        $error("start_ok: expected %0d, actual %0d", want.start_ok, got.start_ok);
        error_count++;
      end
      if (got.fired_mask !== want.fired_mask) begin
        $error("fired_mask: expected 0x%02h, actual 0x%02h", want.fired_mask, got.fired_mask);
        error_count++;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

  endclass

endpackage

// ----- bench/periodic_timer_bank_test.sv -----
// Self-checking testbench for periodic_timer_bank: directed start, stop and
// process transactions, then a long random run with idle bursts on both sides.
// Depends on ptb_pkg, ptb_scoreboard_pkg and the periodic_timer_bank RTL.
module periodic_timer_bank_test;

  import ptb_pkg::*;
  import ptb_scoreboard_pkg::*;

  localparam int RANDOM_COMMANDS = 1930;
  // Cycles without any accepted transaction before the run is declared hung.
  // The slowest legal gap is a sender idle burst plus a receiver stall plus
  // the passage through the bank's registers, so this leaves a wide margin.
  localparam int STALL_LIMIT = 400;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ptb_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ptb_out_t out_data;

  // Set for the final stretch of the run, where neither side idles.
  bit calm = 1'b0;

  logic [TIME_W-1:0] clock_ticks;

  timer_bank_scoreboard board;

  periodic_timer_bank dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Presents one command and holds it until the bank accepts it. The valid
  // line is only lowered when an idle burst comes first, so it is never
  // dropped and raised again within one time step.
  task automatic send_cmd(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                          logic [TIME_W-1:0] period, logic [TIME_W-1:0] now);
    ptb_in_t cmd;
    cmd.operation = op;
    cmd.slot      = slot;
    cmd.period    = period;
    cmd.now       = now;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    board.note_command(cmd);
  endtask

  // Picks a period: mostly short so that slots fire often, with the
  // extremes and fully random values mixed in.
  function automatic logic [TIME_W-1:0] pick_period();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 40);
    if (pick < 80) return '0;
    if (pick < 90) return '1;
    return $urandom();
  endfunction

  // Random traffic. Most commands follow a clock that only moves forward in
  // small steps, so that armed slots actually reach their deadlines, fire on
  // time, or fall behind and resynchronize. Now and then the clock jumps far
  // ahead, and a few commands are pure noise on every field.
  task automatic run_random();
    int unsigned pick;
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n >= RANDOM_COMMANDS * 85 / 100) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send_cmd(OP_START, SLOT_W'($urandom_range(0, 7)), pick_period(), clock_ticks);
      end else if (pick < 36) begin
        send_cmd(OP_STOP, SLOT_W'($urandom_range(0, 7)), $urandom(), $urandom());
      end else if (pick < 92) begin
        if ($urandom_range(0, 19) == 0) begin
          clock_ticks = clock_ticks + $urandom();
        end else begin
          clock_ticks = clock_ticks + $urandom_range(0, 30);
        end
        send_cmd(OP_PROCESS, SLOT_W'($urandom()), $urandom(), clock_ticks);
      end else if (pick < 95) begin
        send_cmd(OP_UNUSED, SLOT_W'($urandom()), $urandom(), $urandom());
      end else begin
        send_cmd(OP_W'($urandom_range(0, 3)), SLOT_W'($urandom()), $urandom(),
                 $urandom());
      end
    end
  endtask

  // Result side: ready comes in runs of random length, broken by stall
  // bursts while the run is not yet in its calm final stretch.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Every accepted result is compared against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_data);
    end
  end

  // Watchdog: gives up once nothing has been accepted for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("periodic_timer_bank_test: errors");
    $finish;
  end

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A zero period fires on every process; a second start on
    // a running slot is refused; stopping an idle slot does nothing.
    send_cmd(OP_START,   3'd0, 32'd0,          32'd100);
    send_cmd(OP_START,   3'd0, 32'd5,          32'd100);
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'd100);
    send_cmd(OP_STOP,    3'd3, 32'd0,          32'd0);
    send_cmd(OP_START,   3'd1, 32'd10,         32'd100);
    // One tick short of the period, then exactly on it.
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'd109);
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'd110);
    // Slot 1 falls far behind, so its reference jumps to now.
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'd150);
    send_cmd(OP_STOP,    3'd0, '1,             '1);
    send_cmd(OP_PROCESS, 3'd7, '1,             32'd160);
    // Largest period on the highest slot, with time wrapping through zero.
    send_cmd(OP_START,   3'd7, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'hFFFF_FFFE);
    send_cmd(OP_START,   3'd2, 32'h8000_0000,  32'd0);
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'h7FFF_FFFF);
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'h8000_0000);
    send_cmd(OP_UNUSED,  3'd7, '1,             '1);
    send_cmd(OP_UNUSED,  3'd0, '0,             '0);
    send_cmd(OP_START,   3'd5, 32'd3,          32'hFFFF_FFFE);
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'd1);
    send_cmd(OP_STOP,    3'd7, 32'd0,          32'd0);
    send_cmd(OP_STOP,    3'd1, 32'd0,          32'd0);
    send_cmd(OP_PROCESS, 3'd0, 32'd0,          32'd4);

    clock_ticks = $urandom();
    run_random();
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (board.error_count == 0 && board.pending() == 0) begin
      $display("periodic_timer_bank_test: clean");
    end else begin
      $display("periodic_timer_bank_test: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ptb_pkg.sv
rtl/core/ptb_slot.sv
rtl/core/periodic_timer_bank.sv
bench/ptb_scoreboard_pkg.sv
bench/periodic_timer_bank_test.sv
